FILE: design/btdq_pkg.sv
package btdq_pkg;

    localparam int HOLD_COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_STICK_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_MAX_TICKS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_TAP_WINDOW = 2'd2;

    localparam logic [6:0] STICK_THRESHOLD_RST   = 7'd50;
    localparam logic [7:0] TAP_MAX_TICKS_RST     = 8'd10;
    localparam logic [7:0] DOUBLE_TAP_WINDOW_RST = 8'd20;

    localparam int FIRE_BIT = 0;

    typedef logic [2:0] fire_event_t;

    localparam fire_event_t EV_NONE         = 3'd0;
    localparam fire_event_t EV_PRESSED      = 3'd1;
    localparam fire_event_t EV_LONG_RELEASE = 3'd2;
    localparam fire_event_t EV_TAP_CACHED   = 3'd3;
    localparam fire_event_t EV_DOUBLE_TAP   = 3'd4;

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } dir_t;

    typedef struct packed {
        logic        held;
        logic        released;
        logic [15:0] hold_length;
        logic [15:0] last_hold_length;
        fire_event_t fire_event;
        logic        single_tap;
    } fire_result_t;

endpackage

FILE: design/btdq_tick_if.sv
interface btdq_tick_if;
    logic              valid;
    logic              ready;
    logic        [7:0] buttons;
    logic signed [7:0] hat_x;
    logic signed [7:0] hat_y;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;

    modport source (output valid, buttons, hat_x, hat_y, stick_x, stick_y, input ready);
    modport sink   (input valid, buttons, hat_x, hat_y, stick_x, stick_y, output ready);
endinterface

FILE: design/btdq_result_if.sv
interface btdq_result_if
    import btdq_pkg::*;
;
    logic        valid;
    logic        ready;
    logic  [7:0] button_mask;
    logic        dir_up;
    logic        dir_down;
    logic        dir_left;
    logic        dir_right;
    logic        fire_held;
    logic        fire_released;
    logic [15:0] hold_length;
    logic [15:0] last_hold_length;
    fire_event_t fire_event;
    logic        single_tap;

    modport source (
        output valid, button_mask, dir_up, dir_down, dir_left, dir_right,
               fire_held, fire_released, hold_length, last_hold_length,
               fire_event, single_tap,
        input  ready
    );
    modport sink (
        input  valid, button_mask, dir_up, dir_down, dir_left, dir_right,
               fire_held, fire_released, hold_length, last_hold_length,
               fire_event, single_tap,
        output ready
    );
endinterface

FILE: design/btdq_cfg_if.sv
interface btdq_cfg_if
    import btdq_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

FILE: design/btdq_dir.sv
module btdq_dir
    import btdq_pkg::*;
(
    input  logic signed [7:0] hat_x,
    input  logic signed [7:0] hat_y,
    input  logic signed [7:0] stick_x,
    input  logic signed [7:0] stick_y,
    input  logic        [6:0] stick_threshold,
    output dir_t              dir
);

    logic signed [8:0] thr_pos;
    logic signed [8:0] thr_neg;
    logic signed [8:0] sx;
    logic signed [8:0] sy;

    always_comb
    begin
        thr_pos = signed'({2'b00, stick_threshold});
        thr_neg = -thr_pos;
        sx      = 9'(stick_x);
        sy      = 9'(stick_y);

        dir.up    = hat_y[7] || (sy < thr_neg);
        dir.down  = (hat_y > 8'sd0) || (sy > thr_pos);
        dir.left  = hat_x[7] || (sx < thr_neg);
        dir.right = (hat_x > 8'sd0) || (sx > thr_pos);
    end

endmodule

FILE: design/btdq_fire.sv
module btdq_fire
    import btdq_pkg::*;
#(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic         fire,
    input  logic   [7:0] tap_max_ticks,
    input  logic   [7:0] double_tap_window,
    output fire_result_t result
);

    localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

    logic                       held_reg;
    logic                       held_next;
    logic [HOLD_COUNT_BITS-1:0] hold_ticks_reg;
    logic [HOLD_COUNT_BITS-1:0] hold_ticks_next;
    logic [15:0]                hold_length_reg;
    logic [15:0]                hold_length_next;
    logic [15:0]                released_length_reg;
    logic [15:0]                released_length_next;
    logic                       tap_pending_reg;
    logic                       tap_pending_next;
    logic [8:0]                 ticks_since_tap_reg;
    logic [8:0]                 ticks_since_tap_next;

    logic [HOLD_COUNT_BITS+15:0] ticks_wide;
    logic [15:0]                 ticks_low;
    logic                        released;
    logic                        single;
    logic                        is_tap;
    logic                        pending_mid;
    fire_event_t                 ev;

    always_comb
    begin
        ticks_wide = {16'b0, hold_ticks_reg};
        ticks_low  = ticks_wide[15:0];
        is_tap     = {8'b0, hold_ticks_reg} <= {{HOLD_COUNT_BITS{1'b0}}, tap_max_ticks};

        held_next            = held_reg;
        hold_ticks_next      = hold_ticks_reg;
        hold_length_next     = hold_length_reg;
        released_length_next = released_length_reg;
        released             = 1'b0;
        single               = 1'b0;
        ev                   = EV_NONE;

        if (fire)
        begin
            if (!held_reg)
            begin
                held_next       = 1'b1;
                hold_ticks_next = '0;
                ev              = EV_PRESSED;
            end
            else
            begin
                hold_length_next = ticks_low;
                if (hold_ticks_reg != HOLD_MAX)
                begin
                    hold_ticks_next = hold_ticks_reg + 1'b1;
                end
            end
        end
        else if (held_reg)
        begin
            released             = 1'b1;
            held_next            = 1'b0;
            released_length_next = ticks_low;
            hold_length_next     = '0;
        end

        // age the cached tap before looking at this tick's release
        pending_mid          = tap_pending_reg;
        ticks_since_tap_next = ticks_since_tap_reg;
        if (tap_pending_reg)
        begin
            ticks_since_tap_next = ticks_since_tap_reg + 1'b1;
            if (ticks_since_tap_next > {1'b0, double_tap_window})
            begin
                pending_mid          = 1'b0;
                ticks_since_tap_next = '0;
                single               = 1'b1;
            end
        end

        tap_pending_next = pending_mid;
        if (released)
        begin
            if (is_tap)
            begin
                ticks_since_tap_next = '0;
                tap_pending_next     = !pending_mid;
                ev                   = pending_mid ? EV_DOUBLE_TAP : EV_TAP_CACHED;
            end
            else
            begin
                ev = EV_LONG_RELEASE;
            end
        end

        result.held             = held_next;
        result.released         = released;
        result.hold_length      = hold_length_next;
        result.last_hold_length = released_length_next;
        result.fire_event       = ev;
        result.single_tap       = single;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg            <= 1'b0;
            hold_ticks_reg      <= '0;
            hold_length_reg     <= '0;
            released_length_reg <= '0;
            tap_pending_reg     <= 1'b0;
            ticks_since_tap_reg <= '0;
        end
        else if (step)
        begin
            held_reg            <= held_next;
            hold_ticks_reg      <= hold_ticks_next;
            hold_length_reg     <= hold_length_next;
            released_length_reg <= released_length_next;
            tap_pending_reg     <= tap_pending_next;
            ticks_since_tap_reg <= ticks_since_tap_next;
        end
    end

endmodule

FILE: design/button_tap_direction_qualifier.sv
// Controller poll qualifier.
// tick (sink): one beat per poll tick with the raw buttons, hat and stick positions.
// result (source): one beat per tick with the button mask, four direction flags
//   and the fire button press / hold / release / tap tracking.
// cfg (sink): register writes (stick threshold, tap length, double-tap window);
//   always ready, a write to an unknown index is dropped. Write only while idle.
// Path: an accepted tick beat passes through the input register and then the
// result register (one input register, one result register).
// Throughput: one tick per cycle while result.ready stays high; the fire state
// update is combinational compares and a counter increment between the two registers.
// Reset: all tracking state clears, registers take their defaults
// (threshold 50, tap 10 ticks, window 20 ticks), both pipeline stages empty.
// Stall: when the receiver holds result.ready low, the result register holds,
// the input register fills behind it and then tick.ready drops; no beat is
// lost and the fire state advances only when a beat moves into the result register.
module button_tap_direction_qualifier
    import btdq_pkg::*;
#(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    btdq_tick_if.sink     tick,
    btdq_result_if.source result,
    btdq_cfg_if.sink      cfg
);

    logic [6:0] stick_threshold_reg;
    logic [7:0] tap_max_ticks_reg;
    logic [7:0] double_tap_window_reg;

    logic              in_valid_reg;
    logic        [7:0] buttons_reg;
    logic signed [7:0] hat_x_reg;
    logic signed [7:0] hat_y_reg;
    logic signed [7:0] stick_x_reg;
    logic signed [7:0] stick_y_reg;

    logic         out_valid_reg;
    logic   [7:0] mask_reg;
    dir_t         dir_reg;
    fire_result_t fire_reg;

    logic         advance;
    dir_t         dir;
    fire_result_t fire_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_threshold_reg   <= STICK_THRESHOLD_RST;
            tap_max_ticks_reg     <= TAP_MAX_TICKS_RST;
            double_tap_window_reg <= DOUBLE_TAP_WINDOW_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_STICK_THRESHOLD:   stick_threshold_reg   <= cfg.reg_data[6:0];
                REG_TAP_MAX_TICKS:     tap_max_ticks_reg     <= cfg.reg_data;
                REG_DOUBLE_TAP_WINDOW: double_tap_window_reg <= cfg.reg_data;
                default:               ;
            endcase
        end
    end

    // move the input register forward when the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            buttons_reg <= tick.buttons;
            hat_x_reg   <= tick.hat_x;
            hat_y_reg   <= tick.hat_y;
            stick_x_reg <= tick.stick_x;
            stick_y_reg <= tick.stick_y;
        end
    end

    btdq_dir u_dir (
        .hat_x           (hat_x_reg),
        .hat_y           (hat_y_reg),
        .stick_x         (stick_x_reg),
        .stick_y         (stick_y_reg),
        .stick_threshold (stick_threshold_reg),
        .dir             (dir)
    );

    btdq_fire #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_fire (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .fire              (buttons_reg[FIRE_BIT]),
        .tap_max_ticks     (tap_max_ticks_reg),
        .double_tap_window (double_tap_window_reg),
        .result            (fire_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= buttons_reg;
            dir_reg  <= dir;
            fire_reg <= fire_res;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.button_mask      = mask_reg;
    assign result.dir_up           = dir_reg.up;
    assign result.dir_down         = dir_reg.down;
    assign result.dir_left         = dir_reg.left;
    assign result.dir_right        = dir_reg.right;
    assign result.fire_held        = fire_reg.held;
    assign result.fire_released    = fire_reg.released;
    assign result.hold_length      = fire_reg.hold_length;
    assign result.last_hold_length = fire_reg.last_hold_length;
    assign result.fire_event       = fire_reg.fire_event;
    assign result.single_tap       = fire_reg.single_tap;

endmodule

FILE: bench/button_tap_direction_qualifier_tb.sv
module button_tap_direction_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btdq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_TICKS = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [7:0]        buttons;
        logic signed [7:0] hat_x;
        logic signed [7:0] hat_y;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        int                gap;
    } poll_tick_t;

    typedef struct packed {
        logic [7:0]   button_mask;
        dir_t         dirs;
        fire_result_t fire;
    } poll_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_off = 1'b0;

    btdq_tick_if   tick_bus ();
    btdq_result_if poll_bus ();
    btdq_cfg_if    cfg_bus ();

    button_tap_direction_qualifier dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_bus),
        .result (poll_bus),
        .cfg    (cfg_bus)
    );

    always #1 clk = ~clk;

    // qualifier model: configuration and fire tracking state
    logic [6:0]  cfg_threshold = STICK_THRESHOLD_RST;
    logic [7:0]  cfg_tap_max   = TAP_MAX_TICKS_RST;
    logic [7:0]  cfg_window    = DOUBLE_TAP_WINDOW_RST;
    logic        fire_down     = 1'b0;
    logic [15:0] hold_count    = '0;
    logic [15:0] hold_len      = '0;
    logic [15:0] last_len      = '0;
    logic        tap_waiting   = 1'b0;
    logic [8:0]  tap_age       = '0;

    poll_tick_t   pending_ticks[$];
    poll_result_t expected_polls[$];

    int  ticks_queued;
    int  ticks_accepted;
    int  results_seen;
    int  mismatches;
    int  reg_writes;
    int  singles_seen;
    int  fire_events[8];
    int  cycles;
    int  gap_count;
    int  stall_left;
    bit  tx_calm;
    bit  rx_calm;

    function automatic poll_result_t qualify_tick(input logic [7:0] btn,
                                                  input int hx, input int hy,
                                                  input int sx, input int sy);
        poll_result_t r;
        logic         was_down;
        int           thr;
        r = '0;
        was_down = fire_down;
        thr = int'(cfg_threshold);
        r.fire.fire_event = EV_NONE;

        if (btn[FIRE_BIT]) begin
            if (!fire_down) begin
                fire_down = 1'b1;
                hold_count = '0;
            end
            else begin
                hold_len = hold_count;
                if (hold_count != '1)
                    hold_count++;
            end
        end
        else if (fire_down) begin
            r.fire.released = 1'b1;
            fire_down = 1'b0;
            last_len = hold_count;
            hold_len = '0;
        end

        // age the cached tap before looking at a new release
        if (tap_waiting) begin
            tap_age = tap_age + 9'd1;
            if (tap_age > cfg_window) begin
                tap_waiting = 1'b0;
                tap_age = '0;
                r.fire.single_tap = 1'b1;
            end
        end

        if (r.fire.released) begin
            if (hold_count <= cfg_tap_max) begin
                tap_age = '0;
                if (tap_waiting) begin
                    tap_waiting = 1'b0;
                    r.fire.fire_event = EV_DOUBLE_TAP;
                end
                else begin
                    tap_waiting = 1'b1;
                    r.fire.fire_event = EV_TAP_CACHED;
                end
            end
            else
                r.fire.fire_event = EV_LONG_RELEASE;
        end
        else if (!was_down && fire_down)
            r.fire.fire_event = EV_PRESSED;

        r.button_mask = btn;
        r.dirs.up     = (hy < 0) || (sy < -thr);
        r.dirs.down   = (hy > 0) || (sy > thr);
        r.dirs.left   = (hx < 0) || (sx < -thr);
        r.dirs.right  = (hx > 0) || (sx > thr);
        r.fire.held   = fire_down;
        r.fire.hold_length      = hold_len;
        r.fire.last_hold_length = last_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] poll %0d: %s got %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    task automatic check_poll();
        poll_result_t got;
        poll_result_t want;
        got.button_mask             = poll_bus.button_mask;
        got.dirs.up                 = poll_bus.dir_up;
        got.dirs.down               = poll_bus.dir_down;
        got.dirs.left               = poll_bus.dir_left;
        got.dirs.right              = poll_bus.dir_right;
        got.fire.held               = poll_bus.fire_held;
        got.fire.released           = poll_bus.fire_released;
        got.fire.hold_length        = poll_bus.hold_length;
        got.fire.last_hold_length   = poll_bus.last_hold_length;
        got.fire.fire_event         = poll_bus.fire_event;
        got.fire.single_tap         = poll_bus.single_tap;
        results_seen++;
        fire_events[got.fire.fire_event]++;
        if (got.fire.single_tap === 1'b1)
            singles_seen++;
        if (expected_polls.size() == 0) begin
            report_mismatch("result beat with nothing pending", 1, 0);
            return;
        end
        want = expected_polls.pop_front();
        if (got.button_mask !== want.button_mask)
            report_mismatch("button_mask", got.button_mask, want.button_mask);
        if (got.dirs.up !== want.dirs.up)
            report_mismatch("dir_up", got.dirs.up, want.dirs.up);
        if (got.dirs.down !== want.dirs.down)
            report_mismatch("dir_down", got.dirs.down, want.dirs.down);
        if (got.dirs.left !== want.dirs.left)
            report_mismatch("dir_left", got.dirs.left, want.dirs.left);
        if (got.dirs.right !== want.dirs.right)
            report_mismatch("dir_right", got.dirs.right, want.dirs.right);
        if (got.fire.held !== want.fire.held)
            report_mismatch("fire_held", got.fire.held, want.fire.held);
        if (got.fire.released !== want.fire.released)
            report_mismatch("fire_released", got.fire.released, want.fire.released);
        if (got.fire.hold_length !== want.fire.hold_length)
            report_mismatch("hold_length", got.fire.hold_length, want.fire.hold_length);
        if (got.fire.last_hold_length !== want.fire.last_hold_length)
            report_mismatch("last_hold_length", got.fire.last_hold_length,
                            want.fire.last_hold_length);
        if (got.fire.fire_event !== want.fire.fire_event)
            report_mismatch("fire_event", got.fire.fire_event, want.fire.fire_event);
        if (got.fire.single_tap !== want.fire.single_tap)
            report_mismatch("single_tap", got.fire.single_tap, want.fire.single_tap);
    endtask

    function automatic int pick_gap(input bit calm);
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 7))
            0: return int'($urandom_range(0, 255)) - 128;
            1: return ($urandom_range(0, 1) ? 1 : -1) *
                      (int'(cfg_threshold) + int'($urandom_range(0, 1)));
            default: return int'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    function automatic int hat_pos();
        return $urandom_range(0, 1) ? 0 : rand_pos();
    endfunction

    task automatic push_tick(input logic [7:0] btn, input int hx, input int hy,
                             input int sx, input int sy);
        poll_tick_t t;
        t.buttons = btn;
        t.hat_x   = 8'(hx);
        t.hat_y   = 8'(hy);
        t.stick_x = 8'(sx);
        t.stick_y = 8'(sy);
        t.gap     = pick_gap(tx_calm);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic push_fire(input logic fire);
        push_tick({7'($urandom), fire}, hat_pos(), hat_pos(), rand_pos(), rand_pos());
    endtask

    // one press/hold/release gesture followed by a quiet stretch, or a burst of noise
    task automatic fire_burst();
        int hold_n;
        int rest;
        int tap_cap;
        tx_calm = ($urandom_range(0, 4) == 0);
        tap_cap = (cfg_tap_max > 20) ? 20 : int'(cfg_tap_max);
        case ($urandom_range(0, 5))
            0: begin
                repeat ($urandom_range(1, 5))
                    push_tick(8'($urandom), rand_pos(), rand_pos(), rand_pos(), rand_pos());
                return;
            end
            1: hold_n = (cfg_tap_max > 40) ? int'($urandom_range(0, tap_cap))
                                           : int'(cfg_tap_max) + 1 + int'($urandom_range(0, 3));
            default: hold_n = $urandom_range(0, tap_cap + 1);
        endcase
        push_fire(1'b1);
        repeat (hold_n)
            push_fire(1'b1);
        push_fire(1'b0);
        rest = (cfg_window > 22) ? 24 : int'(cfg_window) + 2;
        if (cfg_window < 60 && $urandom_range(0, 7) == 0)
            rest = int'(cfg_window) + 2;
        repeat ($urandom_range(0, rest))
            push_fire(1'b0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.reg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_STICK_THRESHOLD:   cfg_threshold = data[6:0];
            REG_TAP_MAX_TICKS:     cfg_tap_max   = data;
            REG_DOUBLE_TAP_WINDOW: cfg_window    = data;
            default: ;
        endcase
    endtask

    // wait until every queued tick has come back, then let the pipeline drain
    task automatic settle();
        while (!(pending_ticks.size() == 0 && !tick_bus.valid && expected_polls.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // tick sender
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tick_bus.valid   <= 1'b0;
            tick_bus.buttons <= '0;
            tick_bus.hat_x   <= '0;
            tick_bus.hat_y   <= '0;
            tick_bus.stick_x <= '0;
            tick_bus.stick_y <= '0;
            gap_count        <= 0;
        end
        else begin
            if (tick_bus.valid && tick_bus.ready) begin
                expected_polls.push_back(qualify_tick(tick_bus.buttons, tick_bus.hat_x,
                                                      tick_bus.hat_y, tick_bus.stick_x,
                                                      tick_bus.stick_y));
                ticks_accepted++;
            end
            if (!tick_bus.valid || tick_bus.ready) begin
                if (pending_ticks.size() != 0 && gap_count >= pending_ticks[0].gap) begin
                    tick_bus.valid   <= 1'b1;
                    tick_bus.buttons <= pending_ticks[0].buttons;
                    tick_bus.hat_x   <= pending_ticks[0].hat_x;
                    tick_bus.hat_y   <= pending_ticks[0].hat_y;
                    tick_bus.stick_x <= pending_ticks[0].stick_x;
                    tick_bus.stick_y <= pending_ticks[0].stick_y;
                    gap_count        <= 0;
                    void'(pending_ticks.pop_front());
                end
                else begin
                    tick_bus.valid <= 1'b0;
                    if (pending_ticks.size() != 0)
                        gap_count <= gap_count + 1;
                end
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n) begin : receiver
        int wait_left;
        if (!rst_n) begin
            poll_bus.ready <= 1'b0;
            stall_left     <= 0;
        end
        else begin
            wait_left = stall_left;
            if (poll_bus.valid && poll_bus.ready) begin
                check_poll();
                wait_left = pick_gap(rx_calm);
                if ($urandom_range(0, 29) == 0)
                    rx_calm = !rx_calm;
            end
            else if (wait_left > 0)
                wait_left--;
            stall_left     <= wait_left;
            poll_bus.ready <= (wait_left == 0) && !hold_off;
        end
    end

    // back-pressure: block the result side long enough to fill the pipeline
    initial begin
        while (ticks_accepted < 150)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_polls.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_start;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.reg_index <= '0;
        cfg_bus.reg_data  <= '0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: presses, tap, double tap, long release, edge positions
        tx_calm = 1'b0;
        push_tick(8'h00, 0, 0, 0, 0);
        push_tick(8'hFF, -100, 100, 0, 0);
        push_tick(8'h01, 100, -100, 0, 0);
        push_tick(8'h00, 0, 0, 51, -51);
        push_tick(8'h01, 0, 0, 50, -50);
        push_tick(8'hFE, 0, 0, -100, 100);
        push_tick(8'h01, 0, 0, -51, 51);
        repeat (11)
            push_tick(8'h01, -128, 127, 127, -128);
        push_tick(8'h80, 0, 0, 0, 0);
        settle();

        // zero threshold and one-tick window: tap expiry, also coinciding with a new tap
        write_reg(REG_STICK_THRESHOLD, 8'd0);
        write_reg(REG_DOUBLE_TAP_WINDOW, 8'd1);
        push_tick(8'h01, 0, 0, 0, 0);
        push_tick(8'h00, 0, 0, 1, -1);
        push_tick(8'h01, 0, 0, -1, 1);
        push_tick(8'h00, 0, 0, 0, 0);
        push_tick(8'h00, 0, 0, 0, 0);
        push_tick(8'h00, 0, 0, 0, 0);

        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(REG_STICK_THRESHOLD, 8'd100);
                    write_reg(REG_TAP_MAX_TICKS, 8'd3);
                    write_reg(REG_DOUBLE_TAP_WINDOW, 8'd5);
                end
                1: begin
                    write_reg(REG_STICK_THRESHOLD, 8'd0);
                    write_reg(REG_TAP_MAX_TICKS, 8'd0);
                    write_reg(REG_DOUBLE_TAP_WINDOW, 8'd0);
                end
                2: begin
                    // top bit of the threshold write falls away
                    write_reg(REG_STICK_THRESHOLD, 8'hFF);
                    write_reg(REG_TAP_MAX_TICKS, 8'hFF);
                    write_reg(REG_DOUBLE_TAP_WINDOW, 8'hFF);
                    write_reg(REG_UNUSED, 8'($urandom));
                end
                default: begin
                    write_reg(REG_STICK_THRESHOLD, 8'($urandom_range(0, 100)));
                    write_reg(REG_TAP_MAX_TICKS, 8'($urandom_range(0, 30)));
                    write_reg(REG_DOUBLE_TAP_WINDOW, 8'($urandom_range(0, 40)));
                end
            endcase
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < PHASE_TICKS)
                fire_burst();
        end
        settle();
        repeat (8) @(posedge clk);

        if (expected_polls.size() != 0)
            report_mismatch("results never delivered", 0, expected_polls.size());
        $display("Covered %0d poll ticks over %0d register writes, with a long result stall.",
                 ticks_accepted, reg_writes);
        $display("Fire events: %0d presses, %0d long, %0d taps, %0d doubles, %0d singles.",
                 fire_events[EV_PRESSED], fire_events[EV_LONG_RELEASE],
                 fire_events[EV_TAP_CACHED], fire_events[EV_DOUBLE_TAP], singles_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
